>>> src/period_to_frequency_text_core_defines.svh
// Assertion macros for the period-to-frequency text formatter checker.
// Used by the checker file only; no other dependencies.
`ifndef PERIOD_TO_FREQUENCY_TEXT_CORE_DEFINES_SVH
`define PERIOD_TO_FREQUENCY_TEXT_CORE_DEFINES_SVH

// Same-cycle implication, reset masks the check
`define PFT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pft check failed (same cycle)");

// Next-cycle implication, reset masks the check
`define PFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pft check failed (next cycle)");

`endif

>>> src/pft_pkg.sv
// Shared types, codes and constant functions of the period-to-frequency formatter.
// No dependencies; imported by controller, datapath, top level and checker.
package pft_pkg;

	// display bytes
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_DOT  = 8'h2E;
	localparam int         SUFFIX_LEN = 3;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CLEAR,
		ST_LEAD,
		ST_INT,
		ST_DOT,
		ST_FRAC,
		ST_SUFFIX
	} state_t;

	// source of the output byte
	typedef enum logic [1:0] {
		SEL_CLEAR,
		SEL_DIGIT,
		SEL_DOT,
		SEL_SUFFIX
	} byte_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      start_div;
		logic      div_step;
		logic      emit;
		byte_sel_t sel;
		logic      dig_next;
		logic      suf_next;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic same_period;
		logic div_last;
		logic dig_zero;
		logic dig_at_point;
		logic dig_at_end;
		logic suf_last;
		logic out_free;
	} status_t;

	// power of ten, elaboration only
	function automatic logic [63:0] pow10(input int n);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < n; i++) begin
			r = r * 64'd10;
		end
		return r;
	endfunction

	// " Hz" suffix characters
	function automatic logic [7:0] suffix_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = 8'h20;
			2'd1:    c = 8'h48;
			default: c = 8'h7A;
		endcase
		return c;
	endfunction

endpackage

>>> src/pft_ctrl.sv
// Sequencing state machine of the period-to-frequency formatter.
// Depends on pft_pkg; drives pft_datapath through cmd_t, reads status_t.
module pft_ctrl import pft_pkg::*; #(
	parameter int FRACTION_DIGITS = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.sel  = SEL_CLEAR;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !status.same_period) begin
					cmd.start_div = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_CLEAR;
					state_d  = ST_LEAD;
				end
			end
			ST_LEAD: begin
				// drop leading zeros, keep the units digit
				if (status.dig_zero && !status.dig_at_point) begin
					cmd.dig_next = 1'b1;
				end else begin
					state_d = ST_INT;
				end
			end
			ST_INT: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_DIGIT;
					cmd.dig_next = 1'b1;
					if (status.dig_at_point) begin
						state_d = (FRACTION_DIGITS > 0) ? ST_DOT : ST_SUFFIX;
					end
				end
			end
			ST_DOT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_DOT;
					state_d  = ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_DIGIT;
					cmd.dig_next = 1'b1;
					if (status.dig_at_end) begin
						state_d = ST_SUFFIX;
					end
				end
			end
			ST_SUFFIX: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_SUFFIX;
					cmd.suf_next = 1'b1;
					if (status.suf_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/pft_datapath.sv
// Datapath: period register, serial restoring divider with shift-add-3 BCD
// conversion, digit and suffix counters, output byte register. Uses pft_pkg.
module pft_datapath import pft_pkg::*; #(
	parameter int FRACTION_DIGITS = 4,
	parameter int SAMPLE_BITS     = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [7:0]             out_code,
	output logic                   out_is_char,
	output logic                   out_last
);

	localparam logic [63:0] DIVIDEND = 64'd1000 * pow10(FRACTION_DIGITS);
	localparam int          DIV_W    = $clog2(DIVIDEND + 64'd1);
	localparam int          BIT_IW   = $clog2(DIV_W);
	localparam int          NDIG     = 4 + FRACTION_DIGITS;
	localparam int          DIG_IW   = $clog2(NDIG);
	localparam logic [DIV_W-1:0] DIVIDEND_C = DIVIDEND[DIV_W-1:0];

	logic [SAMPLE_BITS-1:0] period_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [4*NDIG-1:0]      bcd_q;
	logic [BIT_IW-1:0]      bit_q;
	logic [DIG_IW-1:0]      dig_q;
	logic [1:0]             suf_q;

	logic [SAMPLE_BITS-1:0] period_in;
	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   diff;
	logic                   q_bit;
	logic [4*NDIG-1:0]      bcd_adj;
	logic [3:0]             digit;

	// raise a zero sample to one
	assign period_in = (sample == '0) ? SAMPLE_BITS'(1) : sample;

	// one restoring division step
	assign trial = {rem_q, DIVIDEND_C[bit_q]};
	assign diff  = trial - {1'b0, period_q};
	assign q_bit = (trial >= {1'b0, period_q});

	// add 3 to every BCD digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				(bcd_q[4*d +: 4] + 4'd3) : bcd_q[4*d +: 4];
		end
	end

	assign digit = bcd_q[{dig_q, 2'b00} +: 4];

	// stored period, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (cmd.start_div) begin
			period_q <= period_in;
		end
	end

	// divider, BCD shifter and counters
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q <= '0;
			bcd_q <= '0;
			bit_q <= BIT_IW'(DIV_W - 1);
			dig_q <= DIG_IW'(NDIG - 1);
			suf_q <= '0;
		end else begin
			if (cmd.div_step) begin
				rem_q <= q_bit ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
				bcd_q <= {bcd_adj[4*NDIG-2:0], q_bit};
				bit_q <= bit_q - BIT_IW'(1);
			end
			if (cmd.dig_next) begin
				dig_q <= dig_q - DIG_IW'(1);
			end
			if (cmd.suf_next) begin
				suf_q <= suf_q + 2'd1;
			end
		end
	end

	// output byte register: load on emit, release on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.sel)
				SEL_CLEAR: begin
					out_is_char <= 1'b0;
					out_code    <= CMD_CLEAR;
					out_last    <= 1'b0;
				end
				SEL_DIGIT: begin
					out_is_char <= 1'b1;
					out_code    <= ASCII_ZERO | {4'd0, digit};
					out_last    <= 1'b0;
				end
				SEL_DOT: begin
					out_is_char <= 1'b1;
					out_code    <= ASCII_DOT;
					out_last    <= 1'b0;
				end
				SEL_SUFFIX: begin
					out_is_char <= 1'b1;
					out_code    <= suffix_char(suf_q);
					out_last    <= (suf_q == 2'(SUFFIX_LEN - 1));
				end
				default: begin
					out_is_char <= 1'b0;
					out_code    <= CMD_CLEAR;
					out_last    <= 1'b0;
				end
			endcase
		end
	end

	// status to controller
	assign status.same_period  = (period_in == period_q);
	assign status.div_last     = (bit_q == '0);
	assign status.dig_zero     = (digit == 4'd0);
	assign status.dig_at_point = (dig_q == DIG_IW'(FRACTION_DIGITS));
	assign status.dig_at_end   = (dig_q == '0);
	assign status.suf_last     = (suf_q == 2'(SUFFIX_LEN - 1));
	assign status.out_free     = !out_valid || out_ready;

endmodule

>>> src/period_to_frequency_text_core.sv
// Top level of the period-to-frequency text formatter.
// Depends on pft_pkg, pft_ctrl and pft_datapath.
//
//  channel | dir | tdata                 | tuser        | tlast
//  s_*     | in  | [SAMPLE_BITS-1:0] adc | -            | -
//  m_*     | out | [7:0] code            | is_character | last
//
// An accepted sample whose raised period equals the stored one produces
// nothing. Otherwise the serial divider runs one quotient bit per cycle
// (clog2(1000*10^F + 1) quotient bits, 24 at four fraction digits), the clear
// byte follows, leading zeros are dropped down to the units digit, then one
// byte leaves per cycle while the sink is ready. Reset clears the stored period
// and the output valid flag. A low m_tready holds the current byte and keeps
// the next one from being emitted.
module period_to_frequency_text_core import pft_pkg::*; #(
	parameter int FRACTION_DIGITS = 4,
	parameter int SAMPLE_BITS     = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // [SAMPLE_BITS-1:0] adc_sample
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [7:0]                             m_tdata,  // [7:0] code
	output logic                                   m_tuser,  // [0] is_character
	output logic                                   m_tlast
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	pft_ctrl #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// divider, digits and output register
	pft_datapath #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (s_tdata[SAMPLE_BITS-1:0]),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_code    (m_tdata),
		.out_is_char (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

>>> src/pft_checker.sv
// Port-level checker of the period-to-frequency formatter, bound to the top.
// Depends on pft_pkg and period_to_frequency_text_core_defines.svh for the macros.
`include "period_to_frequency_text_core_defines.svh"

module pft_checker import pft_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	localparam logic [7:0] LAST_CHAR = suffix_char(2'(SUFFIX_LEN - 1));

	// a stalled byte holds
	`PFT_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))

	// a command byte is always the clear command and never closes a run
	`PFT_ASSERT_IMP(a_cmd_clear, m_tvalid && !m_tuser, m_tdata == CMD_CLEAR && !m_tlast)

	// a run always closes with 'z'
	`PFT_ASSERT_IMP(a_last_z, m_tvalid && m_tlast, m_tuser && m_tdata == LAST_CHAR)

	// no sample is taken while a run has just started
	`PFT_ASSERT_IMP(a_busy_in_run, m_tvalid && m_tready && !m_tuser, !s_tready)

endmodule

bind period_to_frequency_text_core pft_checker u_pft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
